### sv/jhsp_pkg.sv
package jhsp_pkg;

    // Limits checked by the parser
    localparam int TABLE_SLOTS    = 4;
    localparam int MAX_COMPONENTS = 4;
    localparam int MAX_SYMBOLS    = 256;

    // Marker codes
    localparam logic [15:0] MARKER_SOS  = 16'hFFDA;
    localparam logic [15:0] MARKER_SOF0 = 16'hFFC0;
    localparam logic [15:0] MARKER_SOF2 = 16'hFFC2;
    localparam logic [15:0] MARKER_DHT  = 16'hFFC4;
    localparam logic [15:0] MARKER_DQT  = 16'hFFDB;

    localparam logic [8:0] QUANT_ENTRIES_8  = 9'd64;
    localparam logic [8:0] QUANT_ENTRIES_16 = 9'd128;
    localparam logic [8:0] HUFF_LENGTHS     = 9'd16;

    // Record kinds
    localparam logic [3:0] REC_SIZE      = 4'd0;
    localparam logic [3:0] REC_DC_COUNT  = 4'd1;
    localparam logic [3:0] REC_AC_COUNT  = 4'd2;
    localparam logic [3:0] REC_DC_SYMBOL = 4'd3;
    localparam logic [3:0] REC_AC_SYMBOL = 4'd4;
    localparam logic [3:0] REC_QUANT     = 4'd5;
    localparam logic [3:0] REC_COMPONENT = 4'd6;
    localparam logic [3:0] REC_SCAN      = 4'd7;
    localparam logic [3:0] REC_ERROR     = 4'd8;

    // Error codes
    localparam logic [15:0] ERR_TABLE_ID   = 16'd1;
    localparam logic [15:0] ERR_COMPONENTS = 16'd2;
    localparam logic [15:0] ERR_SYMBOLS    = 16'd3;
    localparam logic [15:0] ERR_OVERRUN    = 16'd4;
    localparam logic [15:0] ERR_LENGTH     = 16'd5;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } word_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  table_id;
        logic [3:0]  second_table_id;
        logic [7:0]  entry_index;
        logic [15:0] first_value;
        logic [15:0] second_value;
    } record_t;

endpackage

### sv/jhsp_byte_queue.sv
module jhsp_byte_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  jhsp_pkg::word_t push_word,
    output logic           pop_valid,
    input  logic           pop_ready,
    output jhsp_pkg::word_t pop_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jhsp_pkg::word_t   mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

### sv/jhsp_parser.sv
module jhsp_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             word_valid,
    output logic             word_ready,
    input  jhsp_pkg::word_t  word,
    output logic             rec_valid,
    input  logic             rec_ready,
    output jhsp_pkg::record_t rec
);

    localparam logic [4:0] PH_SOI0      = 5'd0;
    localparam logic [4:0] PH_SOI1      = 5'd1;
    localparam logic [4:0] PH_MK0       = 5'd2;
    localparam logic [4:0] PH_MK1       = 5'd3;
    localparam logic [4:0] PH_LEN0      = 5'd4;
    localparam logic [4:0] PH_LEN1      = 5'd5;
    localparam logic [4:0] PH_SOF       = 5'd6;
    localparam logic [4:0] PH_DHT_INFO  = 5'd7;
    localparam logic [4:0] PH_DHT_COUNT = 5'd8;
    localparam logic [4:0] PH_DHT_SYM   = 5'd9;
    localparam logic [4:0] PH_DQT_INFO  = 5'd10;
    localparam logic [4:0] PH_DQT_VAL   = 5'd11;
    localparam logic [4:0] PH_SKIP      = 5'd12;
    localparam logic [4:0] PH_SOS_LEN0  = 5'd13;
    localparam logic [4:0] PH_SOS_LEN1  = 5'd14;
    localparam logic [4:0] PH_SOS_NS    = 5'd15;
    localparam logic [4:0] PH_SOS_CID   = 5'd16;
    localparam logic [4:0] PH_SOS_SEL   = 5'd17;
    localparam logic [4:0] PH_SOS_SS    = 5'd18;
    localparam logic [4:0] PH_SOS_SE    = 5'd19;
    localparam logic [4:0] PH_SOS_AHAL  = 5'd20;
    localparam logic [4:0] PH_DONE      = 5'd21;
    localparam logic [4:0] PH_HALT      = 5'd22;

    typedef struct packed {
        logic [4:0]  phase;
        logic [15:0] marker;
        logic [15:0] seg_len;
        logic [15:0] seen;
        logic [7:0]  held;
        logic [15:0] held_width;
        logic [3:0]  cls;
        logic [3:0]  tbl;
        logic [8:0]  item;
        logic [11:0] sym_total;
        logic [2:0]  comp_count;
        logic [7:0]  scan_start;
        logic [7:0]  scan_end;
    } parse_state_t;

    parse_state_t      st_reg;
    parse_state_t      st_cur;
    parse_state_t      st_next;
    logic              rec_valid_reg;
    logic              rec_valid_next;
    jhsp_pkg::record_t rec_reg;
    jhsp_pkg::record_t step_rec;
    logic              take;
    logic              emit;
    logic              fail;
    logic [15:0]       fail_code;
    logic              done;
    logic              last;
    logic [15:0]       seen_inc;
    logic [11:0]       sum_total;
    logic [8:0]        item_inc;
    logic [7:0]        b;
    logic [15:0]       pair;

    assign word_ready = !rec_valid_reg || rec_ready;
    assign take       = word_valid && word_ready;
    assign rec_valid  = rec_valid_reg;
    assign rec        = rec_reg;
    assign b          = word.data;

    always_comb
    begin
        // start of file clears the whole state before the byte is used
        if (word.sof)
        begin
            st_cur       = '0;
            st_cur.phase = PH_SOI0;
        end
        else
        begin
            st_cur = st_reg;
        end
        st_next   = st_cur;
        emit      = 1'b0;
        fail      = 1'b0;
        fail_code = '0;
        done      = 1'b1;
        step_rec  = '0;
        pair      = {st_cur.held, b};
        seen_inc  = st_cur.seen + 16'd1;
        last      = (seen_inc == (st_cur.seg_len - 16'd2));
        sum_total = st_cur.sym_total + {4'd0, b};
        item_inc  = st_cur.item + 9'd1;

        unique case (st_cur.phase)
            PH_SOI0:
            begin
                st_next.phase = PH_SOI1;
            end
            PH_SOI1:
            begin
                st_next.phase = PH_MK0;
            end
            PH_MK0, PH_LEN0, PH_SOS_LEN0:
            begin
                st_next.held  = b;
                st_next.phase = st_cur.phase + 5'd1;
            end
            PH_MK1:
            begin
                st_next.marker = pair;
                st_next.phase  = (pair == jhsp_pkg::MARKER_SOS) ? PH_SOS_LEN0 : PH_LEN0;
            end
            PH_LEN1:
            begin
                st_next.seg_len = pair;
                st_next.seen    = '0;
                priority if (pair < 16'd2)
                begin
                    fail      = 1'b1;
                    fail_code = jhsp_pkg::ERR_LENGTH;
                end
                else if (pair == 16'd2)
                    st_next.phase = PH_MK0;
                else if (st_cur.marker == jhsp_pkg::MARKER_SOF0
                         || st_cur.marker == jhsp_pkg::MARKER_SOF2)
                    st_next.phase = PH_SOF;
                else if (st_cur.marker == jhsp_pkg::MARKER_DHT)
                    st_next.phase = PH_DHT_INFO;
                else if (st_cur.marker == jhsp_pkg::MARKER_DQT)
                    st_next.phase = PH_DQT_INFO;
                else
                    st_next.phase = PH_SKIP;
            end
            PH_SOF, PH_DHT_INFO, PH_DHT_COUNT, PH_DHT_SYM,
            PH_DQT_INFO, PH_DQT_VAL, PH_SKIP:
            begin
                st_next.seen = seen_inc;
                unique case (st_cur.phase)
                    PH_SOF:
                    begin
                        if (seen_inc == 16'd2 || seen_inc == 16'd4)
                            st_next.held = b;
                        else if (seen_inc == 16'd3)
                            st_next.held_width = pair;
                        else if (seen_inc == 16'd5)
                        begin
                            emit                  = 1'b1;
                            step_rec.kind         = jhsp_pkg::REC_SIZE;
                            step_rec.first_value  = pair;
                            step_rec.second_value = st_cur.held_width;
                        end
                    end
                    PH_DHT_INFO, PH_DQT_INFO:
                    begin
                        st_next.cls = b[7:4];
                        st_next.tbl = b[3:0];
                        if ({1'b0, b[3:0]} >= 5'(jhsp_pkg::TABLE_SLOTS))
                        begin
                            fail      = 1'b1;
                            fail_code = jhsp_pkg::ERR_TABLE_ID;
                        end
                        else
                        begin
                            st_next.item      = '0;
                            st_next.sym_total = '0;
                            st_next.phase     = (st_cur.phase == PH_DHT_INFO)
                                                ? PH_DHT_COUNT : PH_DQT_VAL;
                            done              = 1'b0;
                        end
                    end
                    PH_DHT_COUNT:
                    begin
                        st_next.sym_total    = sum_total;
                        emit                 = 1'b1;
                        step_rec.kind        = (st_cur.cls != '0)
                                               ? jhsp_pkg::REC_AC_COUNT
                                               : jhsp_pkg::REC_DC_COUNT;
                        step_rec.table_id    = st_cur.tbl;
                        step_rec.entry_index = st_cur.item[7:0];
                        step_rec.first_value = {8'd0, b};
                        st_next.item         = item_inc;
                        done                 = 1'b0;
                        if (item_inc == jhsp_pkg::HUFF_LENGTHS)
                        begin
                            if (sum_total > 12'(jhsp_pkg::MAX_SYMBOLS))
                            begin
                                fail      = 1'b1;
                                fail_code = jhsp_pkg::ERR_SYMBOLS;
                            end
                            else
                            begin
                                st_next.item = '0;
                                if (sum_total == '0)
                                begin
                                    st_next.phase = PH_DHT_INFO;
                                    done          = 1'b1;
                                end
                                else
                                begin
                                    st_next.phase = PH_DHT_SYM;
                                end
                            end
                        end
                    end
                    PH_DHT_SYM:
                    begin
                        emit                 = 1'b1;
                        step_rec.kind        = (st_cur.cls != '0)
                                               ? jhsp_pkg::REC_AC_SYMBOL
                                               : jhsp_pkg::REC_DC_SYMBOL;
                        step_rec.table_id    = st_cur.tbl;
                        step_rec.entry_index = st_cur.item[7:0];
                        step_rec.first_value = {8'd0, b};
                        st_next.item         = item_inc;
                        done                 = 1'b0;
                        if ({3'd0, item_inc} >= st_cur.sym_total)
                        begin
                            st_next.phase = PH_DHT_INFO;
                            done          = 1'b1;
                        end
                    end
                    PH_DQT_VAL:
                    begin
                        step_rec.kind     = jhsp_pkg::REC_QUANT;
                        step_rec.table_id = st_cur.tbl;
                        st_next.item      = item_inc;
                        done              = 1'b0;
                        if (st_cur.cls == '0)
                        begin
                            emit                 = 1'b1;
                            step_rec.entry_index = st_cur.item[7:0];
                            step_rec.first_value = {8'd0, b};
                            if (item_inc >= jhsp_pkg::QUANT_ENTRIES_8)
                            begin
                                st_next.phase = PH_DQT_INFO;
                                done          = 1'b1;
                            end
                        end
                        else
                        begin
                            // 16-bit entries: high byte first
                            if (!st_cur.item[0])
                                st_next.held = b;
                            else
                            begin
                                emit                 = 1'b1;
                                step_rec.entry_index = st_cur.item[8:1];
                                step_rec.first_value = pair;
                            end
                            if (item_inc >= jhsp_pkg::QUANT_ENTRIES_16)
                            begin
                                st_next.phase = PH_DQT_INFO;
                                done          = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (last && !fail)
                begin
                    if (!done)
                    begin
                        fail      = 1'b1;
                        fail_code = jhsp_pkg::ERR_OVERRUN;
                    end
                    else
                    begin
                        st_next.phase = PH_MK0;
                    end
                end
            end
            PH_SOS_LEN1:
            begin
                st_next.seg_len = pair;
                st_next.seen    = '0;
                if (pair < 16'd2)
                begin
                    fail      = 1'b1;
                    fail_code = jhsp_pkg::ERR_LENGTH;
                end
                else
                begin
                    st_next.phase = PH_SOS_NS;
                end
            end
            PH_SOS_NS:
            begin
                if (b > 8'(jhsp_pkg::MAX_COMPONENTS))
                begin
                    fail      = 1'b1;
                    fail_code = jhsp_pkg::ERR_COMPONENTS;
                end
                else
                begin
                    st_next.comp_count = b[2:0];
                    st_next.item       = '0;
                    st_next.phase      = (b != '0) ? PH_SOS_CID : PH_SOS_SS;
                end
            end
            PH_SOS_CID:
            begin
                st_next.held  = b;
                st_next.phase = PH_SOS_SEL;
            end
            PH_SOS_SEL:
            begin
                emit                     = 1'b1;
                step_rec.kind            = jhsp_pkg::REC_COMPONENT;
                step_rec.table_id        = b[7:4];
                step_rec.second_table_id = b[3:0];
                step_rec.entry_index     = st_cur.item[7:0];
                step_rec.first_value     = {8'd0, st_cur.held};
                st_next.item             = item_inc;
                st_next.phase            = (item_inc < {6'd0, st_cur.comp_count})
                                           ? PH_SOS_CID : PH_SOS_SS;
            end
            PH_SOS_SS:
            begin
                st_next.scan_start = b;
                st_next.phase      = PH_SOS_SE;
            end
            PH_SOS_SE:
            begin
                st_next.scan_end = b;
                st_next.phase    = PH_SOS_AHAL;
            end
            PH_SOS_AHAL:
            begin
                emit                  = 1'b1;
                step_rec.kind         = jhsp_pkg::REC_SCAN;
                step_rec.entry_index  = b;
                step_rec.first_value  = {8'd0, st_cur.scan_start};
                step_rec.second_value = {8'd0, st_cur.scan_end};
                st_next.phase         = PH_DONE;
            end
            default:
            begin
                // done or halted: bytes are dropped until the next start of file
            end
        endcase

        if (fail)
        begin
            st_next.phase        = PH_HALT;
            emit                 = 1'b1;
            step_rec             = '0;
            step_rec.kind        = jhsp_pkg::REC_ERROR;
            step_rec.first_value = fail_code;
        end

        rec_valid_next = take ? emit : (rec_valid_reg && !rec_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // all-zero state has phase PH_SOI0
            st_reg        <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                st_reg <= st_next;
            end
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            rec_reg <= step_rec;
        end
    end

endmodule

### sv/jpeg_header_segment_parser.sv
// JPEG header parser: takes one file byte per word and returns at most one record per byte
// (size, Huffman counts and symbols, quant entries, scan components and parameters, or an
// error, after which the parser halts until the next start_of_file). Bytes go into a queue of
// QUEUE_DEPTH words, and in_ready is high whenever that queue has room; the parser drains one
// byte per clock from the queue into a single output register, so the sustained rate is one
// byte per cycle as long as out_ready keeps the output register moving. An accepted byte is
// first written into the queue and then parsed from there into the output register.
module jpeg_header_segment_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  record_kind,
    output logic [3:0]  table_id,
    output logic [3:0]  second_table_id,
    output logic [7:0]  entry_index,
    output logic [15:0] first_value,
    output logic [15:0] second_value
);

    jhsp_pkg::word_t   in_word;
    jhsp_pkg::word_t   q_word;
    logic              q_valid;
    logic              q_ready;
    jhsp_pkg::record_t rec;

    assign in_word.data = data_byte;
    assign in_word.sof  = start_of_file;

    jhsp_byte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_word  (in_word),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_word)
    );

    jhsp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (q_valid),
        .word_ready (q_ready),
        .word       (q_word),
        .rec_valid  (out_valid),
        .rec_ready  (out_ready),
        .rec        (rec)
    );

    assign record_kind     = rec.kind;
    assign table_id        = rec.table_id;
    assign second_table_id = rec.second_table_id;
    assign entry_index     = rec.entry_index;
    assign first_value     = rec.first_value;
    assign second_value    = rec.second_value;

endmodule
